[src/barcode_molecule_merger_defines.svh]
// Assertion macros shared by the barcode molecule merger checker.
`ifndef BARCODE_MOLECULE_MERGER_DEFINES_SVH
`define BARCODE_MOLECULE_MERGER_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define BMM_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Property that is also checked while reset is asserted.
`define BMM_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

[src/bmm_pkg.sv]
// Shared types and constants of the barcode molecule merger.
`default_nettype none
package bmm_pkg;

  localparam int POS_W     = 31;
  localparam int BC_W      = 32;
  localparam int READS_W   = 16;
  localparam int COV_Q_W   = 32;
  localparam int LEN_W     = POS_W + 1;
  localparam int Q_FRAC    = 16;
  localparam int COV_MUL_W = 8;
  localparam int COV_B_W   = READS_W + COV_MUL_W;
  localparam int COV_W     = COV_B_W + Q_FRAC;
  localparam int PROD_W    = COV_Q_W + POS_W;

  localparam logic [COV_MUL_W-1:0] COV_PER_READ = 8'd180;
  localparam logic [READS_W-1:0]   READS_MAX    = 16'hFFFF;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_GAP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOL_EXT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_READS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COV_Q  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COV_Q  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 3'd5;
  localparam int CFG_DATA_W = 32;

  localparam logic [POS_W-1:0]   RST_EXT_GAP    = 31'd20000;
  localparam logic [POS_W-1:0]   RST_MOL_EXT    = 31'd20000;
  localparam logic [READS_W-1:0] RST_MIN_READS  = 16'd4;
  localparam logic [COV_Q_W-1:0] RST_MIN_COV_Q  = 32'd0;
  localparam logic [COV_Q_W-1:0] RST_MAX_COV_Q  = 32'hFFFF_FFFF;
  localparam logic [POS_W-1:0]   RST_MIN_LENGTH = 31'd1000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [POS_W-1:0]   ext_gap;
    logic [POS_W-1:0]   mol_ext;
    logic [READS_W-1:0] min_reads;
    logic [COV_Q_W-1:0] min_cov_q;
    logic [COV_Q_W-1:0] max_cov_q;
    logic [POS_W-1:0]   min_length;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   start;
    logic [POS_W-1:0]   stop;
    logic [BC_W-1:0]    barcode;
    logic [READS_W-1:0] reads;
  } mol_t;

  // Molecules closed by one read: the one closed on arrival, then the one
  // flushed by the last-read flag.
  typedef struct packed {
    logic a_valid;
    mol_t a;
    logic b_valid;
    mol_t b;
  } pair_t;

endpackage
`default_nettype wire

[src/bmm_front.sv]
// Front end: merges incoming reads into the open molecule and closes molecules.
`default_nettype none
module bmm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  bmm_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bmm_pkg::BC_W-1:0]      barcode,
  input  logic [bmm_pkg::POS_W-1:0]     read_start,
  input  logic [bmm_pkg::POS_W-1:0]     read_end,
  input  logic                          is_last,
  output logic                          push,
  output bmm_pkg::pair_t                push_data,
  input  logic                          queue_full
);
  import bmm_pkg::*;

  logic               open_valid;
  logic               group_multi;
  logic [BC_W-1:0]    open_barcode;
  logic [POS_W-1:0]   open_start;
  logic [POS_W-1:0]   open_end;
  logic [READS_W-1:0] open_reads;

  logic               accept;
  logic               same;
  logic [LEN_W-1:0]   gap_diff;
  logic [LEN_W-1:0]   ext_sum;
  logic               merge;
  logic [READS_W-1:0] reads_inc;
  logic [POS_W-1:0]   start_next;
  logic [READS_W-1:0] reads_next;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign same     = open_valid && (barcode == open_barcode);

  // Merge when the gap to the molecule end is small, or the read starts
  // inside the extension window from the molecule start.
  assign gap_diff  = {1'b0, read_start} - {1'b0, open_end};
  assign ext_sum   = {1'b0, open_start} + {1'b0, cfg.mol_ext};
  assign merge     = ($signed(gap_diff) < $signed({1'b0, cfg.ext_gap})) ||
                     (ext_sum > {1'b0, read_start});
  assign reads_inc = (open_reads == READS_MAX) ? open_reads : open_reads + 1'b1;

  assign start_next = (same && merge) ? open_start : read_start;
  assign reads_next = (same && merge) ? reads_inc : READS_W'(1);

  always_comb begin
    push_data.a_valid   = open_valid && (same ? !merge : group_multi);
    push_data.a.start   = open_start;
    push_data.a.stop    = open_end;
    push_data.a.barcode = open_barcode;
    push_data.a.reads   = open_reads;
    push_data.b_valid   = is_last && same;
    push_data.b.start   = start_next;
    push_data.b.stop    = read_end;
    push_data.b.barcode = barcode;
    push_data.b.reads   = reads_next;
  end

  assign push = accept && (push_data.a_valid || push_data.b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_valid  <= 1'b0;
      group_multi <= 1'b0;
    end else if (accept) begin
      open_valid  <= !is_last;
      group_multi <= same && !is_last;
    end
    if (accept) begin
      open_barcode <= barcode;
      open_start   <= start_next;
      open_end     <= read_end;
      open_reads   <= reads_next;
    end
  end

endmodule
`default_nettype wire

[src/bmm_queue.sv]
// Short queue of closed molecule pairs between the front and back ends.
`default_nettype none
module bmm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bmm_pkg::pair_t push_data,
  output logic           full,
  output logic           head_valid,
  output bmm_pkg::pair_t head,
  input  logic           pop
);
  import bmm_pkg::*;

  pair_t               entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign full       = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

[src/bmm_back.sv]
// Back end: filters closed molecules and sets the last flag of each request.
`default_nettype none
module bmm_back (
  input  logic           clk,
  input  logic           rst,
  input  bmm_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  bmm_pkg::pair_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output bmm_pkg::mol_t  out_mol,
  output logic           out_last
);
  import bmm_pkg::*;

  // Selection of one molecule from the head pair
  logic               sub;
  mol_t               sel_mol;
  logic               sel_fin;
  logic               sel_fire;

  // Stage 1: length, read count check, coverage numerator
  logic               v1;
  mol_t               m1;
  logic               fin1;
  logic [LEN_W-1:0]   len1;
  logic               reads_ok1;
  logic [COV_W-1:0]   cov1;
  logic [COV_B_W-1:0] cov_base;

  // Stage 2: length check and coverage bound products
  logic               v2;
  mol_t               m2;
  logic               fin2;
  logic               base_ok2;
  logic [COV_W-1:0]   cov2;
  logic [PROD_W-1:0]  lo2;
  logic [PROD_W-1:0]  hi2;

  // Stage 3: decision
  logic               v3;
  mol_t               m3;
  logic               fin3;
  logic               acc3;

  // Pending molecule waiting to learn whether it is the last of its read
  logic               pend_valid;
  logic               pend_done;
  mol_t               pend;

  logic               ready1;
  logic               ready2;
  logic               ready3;
  logic               out_free;
  logic               need_out;
  logic               take;
  logic               flush;

  assign sel_fin  = !(head.a_valid && !sub && head.b_valid);
  assign sel_mol  = (head.a_valid && !sub) ? head.a : head.b;
  assign sel_fire = head_valid && ready1;
  assign pop      = sel_fire && sel_fin;

  assign ready3 = !v3 || take;
  assign ready2 = !v2 || ready3;
  assign ready1 = !v1 || ready2;

  assign cov_base = {{COV_MUL_W{1'b0}}, sel_mol.reads} * {{READS_W{1'b0}}, COV_PER_READ};

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
    end else begin
      if (sel_fire) begin
        sub <= !sel_fin;
      end
      if (ready1) begin
        v1 <= head_valid;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
    if (sel_fire) begin
      m1        <= sel_mol;
      fin1      <= sel_fin;
      len1      <= {1'b0, sel_mol.stop} - {1'b0, sel_mol.start};
      reads_ok1 <= sel_mol.reads >= cfg.min_reads;
      cov1      <= {cov_base, {Q_FRAC{1'b0}}};
    end
    if (v1 && ready2) begin
      m2       <= m1;
      fin2     <= fin1;
      cov2     <= cov1;
      // A non-positive length never exceeds the limit, so the low bits of
      // the length are enough for the products.
      base_ok2 <= reads_ok1 && ($signed(len1) > $signed({1'b0, cfg.min_length}));
      lo2      <= {{POS_W{1'b0}}, cfg.min_cov_q} * {{COV_Q_W{1'b0}}, len1[POS_W-1:0]};
      hi2      <= {{POS_W{1'b0}}, cfg.max_cov_q} * {{COV_Q_W{1'b0}}, len1[POS_W-1:0]};
    end
    if (v2 && ready3) begin
      m3   <= m2;
      fin3 <= fin2;
      acc3 <= base_ok2 &&
              ({{(PROD_W-COV_W){1'b0}}, cov2} > lo2) &&
              ({{(PROD_W-COV_W){1'b0}}, cov2} < hi2);
    end
  end

  assign out_free = !out_valid || out_ready;
  assign need_out = fin3 && (acc3 || pend_valid);
  assign take     = v3 && !pend_done && (!need_out || out_free);
  assign flush    = pend_done && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
      pend_done  <= 1'b0;
    end else begin
      if (flush || (take && need_out)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (flush) begin
        pend_valid <= 1'b0;
        pend_done  <= 1'b0;
      end else if (take) begin
        if (acc3 && !fin3) begin
          pend_valid <= 1'b1;
        end else if (fin3 && pend_valid) begin
          pend_valid <= acc3;
          pend_done  <= acc3;
        end
      end
    end
    if (flush) begin
      out_mol  <= pend;
      out_last <= 1'b1;
    end else if (take && need_out) begin
      out_mol  <= pend_valid ? pend : m3;
      out_last <= !(pend_valid && acc3);
    end
    if (take && acc3 && (!fin3 || pend_valid)) begin
      pend <= m3;
    end
  end

endmodule
`default_nettype wire

[src/barcode_molecule_merger.sv]
// Top level of the barcode molecule merger: ports, configuration and wiring.
`default_nettype none
// Read intervals enter on the slave stream sorted by barcode and then start,
// one request per cycle while not stalled; a molecule request leaves on the
// master stream whenever a closed molecule passes the read count, length and
// coverage filters. A read with the same barcode extends the open molecule
// when its start lies less than extension_gap past the molecule end, or
// before the molecule start plus molecule_extension; otherwise, or on a new
// barcode, the open molecule is closed and the read opens the next one. A
// read with tlast set also closes the molecule it leaves open, and tlast on
// the master side marks the final molecule caused by one read. Molecules of
// a barcode that had only one read are dropped. Coverage is 180 bases per
// read over the length, tested exactly by cross-multiplication against the
// Q16.16 bounds. The front end takes one read per cycle and stalls only when
// its four-entry queue of closed molecule pairs is full; the back end
// filters one molecule per cycle through three stages while its output is
// not stalled, so a read that closes two molecules passes them in turn,
// and when both pass, the second waits behind the first at the output.
// Configuration is written through cfg_wen while no read is in flight;
// writes to indexes beyond the six registers are ignored.
module barcode_molecule_merger (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // barcode [31:0], read_start [62:32], read_end [93:63], zero [95:94]
  input  logic [95:0]                       s_axis_tdata,
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // mol_start [30:0], mol_end [61:31], mol_barcode [93:62],
  // mol_reads [109:94], zero [111:110]
  output logic [111:0]                      m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_wen,
  input  logic [bmm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bmm_pkg::*;

  cfg_t  cfg;
  logic  push;
  pair_t push_data;
  logic  queue_full;
  logic  head_valid;
  pair_t head;
  logic  pop;
  mol_t  out_mol;

  // Configuration registers, each masked to its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext_gap    <= RST_EXT_GAP;
      cfg.mol_ext    <= RST_MOL_EXT;
      cfg.min_reads  <= RST_MIN_READS;
      cfg.min_cov_q  <= RST_MIN_COV_Q;
      cfg.max_cov_q  <= RST_MAX_COV_Q;
      cfg.min_length <= RST_MIN_LENGTH;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_EXT_GAP:    cfg.ext_gap    <= cfg_wdata[POS_W-1:0];
        REG_MOL_EXT:    cfg.mol_ext    <= cfg_wdata[POS_W-1:0];
        REG_MIN_READS:  cfg.min_reads  <= cfg_wdata[READS_W-1:0];
        REG_MIN_COV_Q:  cfg.min_cov_q  <= cfg_wdata[COV_Q_W-1:0];
        REG_MAX_COV_Q:  cfg.max_cov_q  <= cfg_wdata[COV_Q_W-1:0];
        REG_MIN_LENGTH: cfg.min_length <= cfg_wdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  bmm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .barcode    (s_axis_tdata[31:0]),
    .read_start (s_axis_tdata[62:32]),
    .read_end   (s_axis_tdata[93:63]),
    .is_last    (s_axis_tlast),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  bmm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bmm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_mol    (out_mol),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_mol.reads, out_mol.barcode, out_mol.stop, out_mol.start};

endmodule
`default_nettype wire

[src/bmm_checker.sv]
// Port-level checks of the barcode molecule merger, bound to its top level.
`default_nettype none
`include "barcode_molecule_merger_defines.svh"
module bmm_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [111:0] m_axis_tdata,
  input logic         m_axis_tlast
);

  // A stalled molecule request keeps its contents.
  `BMM_ASSERT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output changed")

  // Nothing is offered in the cycle after reset.
  `BMM_ASSERT_ALWAYS(a_out_reset, clk, rst |=> !m_axis_tvalid, "output valid after reset")

  // The length filter only passes molecules whose end lies past the start.
  `BMM_ASSERT(a_out_length, clk, rst, m_axis_tvalid |-> (m_axis_tdata[61:31] > m_axis_tdata[30:0]), "molecule with no length emitted")

  // Every emitted molecule holds at least one read.
  `BMM_ASSERT(a_out_reads, clk, rst, m_axis_tvalid |-> (m_axis_tdata[109:94] != 16'd0), "molecule without reads emitted")

endmodule

bind barcode_molecule_merger bmm_checker u_bmm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
